[hw/rtl/jbp_pkg.sv]
// Shared types and constants for the JPEG bit packer.
package jbp_pkg;

  // Command codes carried by an input item.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Widest code the upstream coder may send, and the width of the code field.
  localparam int MAX_CODE_BITS   = 16;
  localparam int CODE_FIELD_BITS = 16;

  // Saturation limit for the bit count: the smaller of the two above.
  localparam logic [4:0] CODE_LIMIT =
    5'((MAX_CODE_BITS < CODE_FIELD_BITS) ? MAX_CODE_BITS : CODE_FIELD_BITS);

  // Marker byte that needs a stuffed zero after it, and the stuffed byte.
  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [7:0] STUFF_BYTE  = 8'h00;

  // One queue entry: one or two completed bytes from a single item.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
  } jbp_entry_t;

endpackage

[hw/rtl/jbp_front.sv]
// Front end: accepts items, merges code bits with pending bits, forms bytes.
module jbp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [4:0]        in_bit_count,
  input  logic [15:0]       in_code_value,
  input  logic              q_ready,
  output logic              q_push,
  output jbp_pkg::jbp_entry_t q_entry
);
  import jbp_pkg::*;

  logic [6:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic        accept;
  logic [4:0]  cnt_sat;
  logic [15:0] code_l;
  logic [7:0]  pend_l;
  logic [23:0] window;
  logic [4:0]  total;
  logic [1:0]  nbytes;
  logic [2:0]  new_cnt;
  logic [7:0]  left_byte;
  logic [7:0]  flush_byte;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Left-align pending bits and code bits into one 24-bit window.
  always_comb begin
    cnt_sat    = (in_bit_count > CODE_LIMIT) ? CODE_LIMIT : in_bit_count;
    code_l     = in_code_value << (5'd16 - cnt_sat);
    pend_l     = 8'({1'b0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r}));
    window     = {pend_l, 16'h0000} | ({code_l, 8'h00} >> pend_cnt_r);
    total      = {2'b00, pend_cnt_r} + cnt_sat;
    nbytes     = total[4:3];
    new_cnt    = total[2:0];
    flush_byte = pend_l | (8'hFF >> pend_cnt_r);
  end

  // Pick the partial byte that stays behind after the completed ones.
  always_comb begin
    case (nbytes)
      2'd0:    left_byte = window[23:16];
      2'd1:    left_byte = window[15:8];
      default: left_byte = window[7:0];
    endcase
  end

  // Queue entry and next pending state for the current item.
  always_comb begin
    q_entry      = '0;
    q_push       = 1'b0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (accept) begin
      if (in_command == CMD_FLUSH) begin
        q_entry.byte0 = flush_byte;
        q_push        = (pend_cnt_r != 3'd0);
        pend_bits_nxt = 7'd0;
        pend_cnt_nxt  = 3'd0;
      end else begin
        q_entry.byte0 = window[23:16];
        q_entry.byte1 = window[15:8];
        q_entry.two   = nbytes[1];
        q_push        = (nbytes != 2'd0);
        pend_bits_nxt = 7'(left_byte >> (4'd8 - {1'b0, new_cnt}));
        pend_cnt_nxt  = new_cnt;
      end
    end
  end

  // Pending bit state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= 7'd0;
      pend_cnt_r  <= 3'd0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  // A flush always leaves nothing pending.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == CMD_FLUSH |=> pend_cnt_r == 3'd0 && pend_bits_r == 7'd0)
    else $error("pending bits survive a flush");

endmodule

[hw/rtl/jbp_queue.sv]
// Two-entry queue that decouples the front end from the byte sequencer.
module jbp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jbp_pkg::jbp_entry_t push_entry,
  output logic                not_full,
  input  logic                pop,
  output logic                not_empty,
  output jbp_pkg::jbp_entry_t head
);
  import jbp_pkg::*;

  jbp_entry_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Occupancy never exceeds the two slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue occupancy out of range");

endmodule

[hw/rtl/jbp_back.sv]
// Back end: sends queued bytes one per transfer and inserts stuffed zeros.
module jbp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  jbp_pkg::jbp_entry_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last_of_item
);
  import jbp_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       sel_r, sel_nxt;
  logic       stuff_r, stuff_nxt;
  logic       stuff_last_r, stuff_last_nxt;
  logic       can_load;
  logic [7:0] data_byte;
  logic       final_data;

  assign can_load   = !out_valid_r || out_ready;
  assign data_byte  = sel_r ? q_head.byte1 : q_head.byte0;
  assign final_data = (sel_r == q_head.two);

  // Choose the next byte: a pending stuffed zero first, else the head entry.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    sel_nxt        = sel_r;
    stuff_nxt      = stuff_r;
    stuff_last_nxt = stuff_last_r;
    q_pop          = 1'b0;
    if (can_load) begin
      if (stuff_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = STUFF_BYTE;
        out_last_nxt  = stuff_last_r;
        stuff_nxt     = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = data_byte;
        q_pop         = final_data;
        sel_nxt       = !final_data;
        if (data_byte == MARKER_BYTE) begin
          out_last_nxt   = 1'b0;
          stuff_nxt      = 1'b1;
          stuff_last_nxt = final_data;
        end else begin
          out_last_nxt = final_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      sel_r        <= 1'b0;
      stuff_r      <= 1'b0;
      stuff_last_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      sel_r        <= sel_nxt;
      stuff_r      <= stuff_nxt;
      stuff_last_r <= stuff_last_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_item = out_last_r;

  // A transferred marker byte is followed at once by a stuffed zero.
  a_stuff_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && out_byte_r == MARKER_BYTE
    |=> out_valid_r && out_byte_r == STUFF_BYTE)
    else $error("marker byte not followed by stuffed zero");

  // A marker byte never ends an item; when it is the item's last data byte, its stuffed zero does.
  a_marker_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_byte_r == MARKER_BYTE |-> !out_last_r)
    else $error("marker byte flagged as last of item");

endmodule

[hw/rtl/jpeg_bit_packer_with_stuffing.sv]
// Top level of the JPEG entropy-segment bit packer with byte stuffing.
// Each input transfer is either a code write (up to 16 bits, sent most
// significant first) or a flush that pads the partial byte with ones. The
// front end takes one item per cycle whenever the two-entry queue has room
// and forms up to two complete bytes per item in that cycle; the back end
// sends one byte per output transfer, adding a zero after every 0xFF, so an
// item yields between zero and four output bytes. Sustained throughput
// is therefore set by the output port: one stream byte per clock while
// out_ready is high. The last byte an item causes carries
// out_last_of_item; items that complete no byte produce no output.
module jpeg_bit_packer_with_stuffing (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [4:0]  in_bit_count,
  input  logic [15:0] in_code_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_item
);
  import jbp_pkg::*;

  logic       q_ready;
  logic       q_push;
  jbp_entry_t q_entry;
  logic       q_valid;
  logic       q_pop;
  jbp_entry_t q_head;

  // Front end: bit merging and byte forming.
  jbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_bit_count (in_bit_count),
    .in_code_value(in_code_value),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // Queue between the two halves.
  jbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .not_full  (q_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Back end: byte sequencing and stuffing.
  jbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_item(out_last_of_item)
  );

endmodule
